// File: sv/dlq_pkg.sv
package dlq_pkg;

  // Pool geometry. The handle and link widths follow from the pool depth.
  localparam int DLQ_POOL_DEPTH  = 16;
  localparam int DLQ_VALUE_WIDTH = 32;
  localparam int HANDLE_W        = $clog2(DLQ_POOL_DEPTH);
  localparam int LINK_W          = $clog2(DLQ_POOL_DEPTH + 1);

  // Link code for "no node".
  localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(DLQ_POOL_DEPTH);

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_PREPEND = 3'd1,
    REQ_POP_L   = 3'd2,
    REQ_POP_R   = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_READ    = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  // Link updates for one request. The alloc write fills a fresh node; the
  // two link writes patch neighbors and take priority over the alloc write.
  typedef struct packed {
    logic                alloc_en;
    logic [HANDLE_W-1:0] alloc_idx;
    logic [LINK_W-1:0]   alloc_prev;
    logic [LINK_W-1:0]   alloc_next;
    logic                nlink_en;
    logic [HANDLE_W-1:0] nlink_idx;
    logic [LINK_W-1:0]   nlink_val;
    logic                plink_en;
    logic [HANDLE_W-1:0] plink_idx;
    logic [LINK_W-1:0]   plink_val;
  } node_wr_t;

endpackage

// File: sv/linked_deque_node_pool.sv
// Channel   | Dir | tuser           | tdata (lowest bit up)
// s_axis    | in  | req_type [2:0]  | item_value, node_handle, zero pad
// m_axis    | out | status [1:0]    | value_out, node_out, next_out, prev_out,
//           |     |                 | head_out, tail_out, count_out, zero pad
//
// One request per clock while m_axis is not stalled. A request waits in the input register,
// the deque update and its result are worked out from that register against the
// node store and the free-node encoder, and the result lands in the output
// register, which drives m_axis valid.
// Reset (rst_ni low, async) empties the deque: no nodes in use, head and
// tail none, count zero. Node contents are not cleared.
// A stalled m_axis holds the result; the input register then fills and
// s_axis_tready drops until the result is taken.
module linked_deque_node_pool #(
  parameter int  VALUE_WIDTH = dlq_pkg::DLQ_VALUE_WIDTH,
  localparam int IN_W  = ((VALUE_WIDTH + dlq_pkg::HANDLE_W + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_WIDTH + 6 * dlq_pkg::LINK_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // item_value, node_handle
  input  logic [2:0]       s_axis_tuser_i,   // req_type
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // value_out, node_out, next_out, prev_out, head_out, tail_out, count_out
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o    // status
);
  import dlq_pkg::*;

  localparam logic [LINK_W-1:0] DEPTH_L = LINK_W'(DLQ_POOL_DEPTH);

  // Input register
  logic                   in_valid_q;
  logic [2:0]             in_req_q;
  logic [VALUE_WIDTH-1:0] in_val_q;
  logic [HANDLE_W-1:0]    in_hdl_q;

  // Deque state
  logic [DLQ_POOL_DEPTH-1:0] used_q, used_d;
  logic [LINK_W-1:0]         head_q, head_d;
  logic [LINK_W-1:0]         tail_q, tail_d;
  logic [LINK_W-1:0]         count_q, count_d;

  // Output register
  logic                   out_valid_q;
  logic [1:0]             out_status_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic [LINK_W-1:0]      out_node_q, out_next_q, out_prev_q;
  logic [LINK_W-1:0]      out_head_q, out_tail_q, out_count_q;

  logic load;
  assign load            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q <= s_axis_tuser_i;
      in_val_q <= s_axis_tdata_i[VALUE_WIDTH-1:0];
      in_hdl_q <= s_axis_tdata_i[VALUE_WIDTH +: HANDLE_W];
    end
  end

  // Free node search and node storage
  logic                free_found;
  logic [HANDLE_W-1:0] free_idx;

  dlq_free_enc u_free_enc (
    .used_i  (used_q),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  node_wr_t               wr;
  logic [LINK_W-1:0]      target;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [LINK_W-1:0]      rd_next, rd_prev;

  dlq_node_store #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_node_store (
    .clk_i      (clk_i),
    .wr_en_i    (load),
    .wr_i       (wr),
    .wr_value_i (in_val_q),
    .rd_idx_i   (target[HANDLE_W-1:0]),
    .rd_value_o (rd_value),
    .rd_next_o  (rd_next),
    .rd_prev_o  (rd_prev)
  );

  // Request decode: one node read (head, tail or handle) per request
  logic                   tgt_used;
  logic                   do_unlink;
  logic                   empty_like;
  status_e                status_d;
  logic [VALUE_WIDTH-1:0] value_d;
  logic [LINK_W-1:0]      node_d, next_d, prev_d;
  logic [LINK_W-1:0]      free_link;

  always_comb begin
    if (in_req_q == REQ_POP_L) begin
      target = head_q;
    end else if (in_req_q == REQ_POP_R) begin
      target = tail_q;
    end else begin
      target = LINK_W'(in_hdl_q);
    end
  end

  assign tgt_used   = (target < DEPTH_L) && used_q[target[HANDLE_W-1:0]];
  assign free_link  = LINK_W'(free_idx);
  assign empty_like = (count_q == '0) || (head_q >= DEPTH_L) || (tail_q >= DEPTH_L);

  always_comb begin
    status_d  = ST_OK;
    value_d   = '0;
    node_d    = NO_NODE;
    next_d    = NO_NODE;
    prev_d    = NO_NODE;
    used_d    = used_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    wr        = '0;
    do_unlink = 1'b0;

    case (in_req_q)
      REQ_APPEND, REQ_PREPEND: begin
        if (!free_found) begin
          status_d = ST_FULL;
        end else begin
          used_d[free_idx] = 1'b1;
          wr.alloc_en      = 1'b1;
          wr.alloc_idx     = free_idx;
          wr.alloc_prev    = NO_NODE;
          wr.alloc_next    = NO_NODE;
          if (empty_like) begin
            head_d = free_link;
            tail_d = free_link;
          end else if (in_req_q == REQ_APPEND) begin
            wr.alloc_prev = tail_q;
            wr.nlink_en   = 1'b1;
            wr.nlink_idx  = tail_q[HANDLE_W-1:0];
            wr.nlink_val  = free_link;
            tail_d        = free_link;
          end else begin
            wr.alloc_next = head_q;
            wr.plink_en   = 1'b1;
            wr.plink_idx  = head_q[HANDLE_W-1:0];
            wr.plink_val  = free_link;
            head_d        = free_link;
          end
          count_d = count_q + LINK_W'(1);
          node_d  = free_link;
        end
      end
      REQ_POP_L, REQ_POP_R: begin
        if (count_q == '0 || !tgt_used) begin
          status_d = ST_EMPTY;
        end else begin
          value_d   = rd_value;
          node_d    = target;
          do_unlink = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (!tgt_used) begin
          status_d = ST_BAD;
        end else begin
          node_d    = target;
          do_unlink = 1'b1;
        end
      end
      REQ_READ: begin
        if (!tgt_used) begin
          status_d = ST_BAD;
        end else begin
          value_d = rd_value;
          node_d  = target;
          next_d  = rd_next;
          prev_d  = rd_prev;
        end
      end
      default: begin
      end
    endcase

    // Splice the target out: neighbors point past it, ends move inward.
    if (do_unlink) begin
      if (target == head_q) begin
        head_d = rd_next;
      end
      if (target == tail_q) begin
        tail_d = rd_prev;
      end
      if (rd_prev < DEPTH_L) begin
        wr.nlink_en  = 1'b1;
        wr.nlink_idx = rd_prev[HANDLE_W-1:0];
        wr.nlink_val = rd_next;
      end
      if (rd_next < DEPTH_L) begin
        wr.plink_en  = 1'b1;
        wr.plink_idx = rd_next[HANDLE_W-1:0];
        wr.plink_val = rd_prev;
      end
      used_d[target[HANDLE_W-1:0]] = 1'b0;
      if (count_q != '0) begin
        count_d = count_q - LINK_W'(1);
      end
    end

    if (count_d == '0) begin
      head_d = NO_NODE;
      tail_d = NO_NODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      head_q      <= NO_NODE;
      tail_q      <= NO_NODE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        used_q  <= used_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= status_d;
      out_value_q  <= value_d;
      out_node_q   <= node_d;
      out_next_q   <= next_d;
      out_prev_q   <= prev_d;
      out_head_q   <= head_d;
      out_tail_q   <= tail_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_W'({out_count_q, out_tail_q, out_head_q, out_prev_q,
                                   out_next_q, out_node_q, out_value_q});

`ifndef SYNTHESIS
  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == LINK_W'($countones(used_q)))
    else $error("node count differs from used map");

  a_empty_no_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == NO_NODE && tail_q == NO_NODE))
    else $error("empty deque keeps a head or tail");

  a_head_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != NO_NODE) |-> used_q[head_q[HANDLE_W-1:0]])
    else $error("head points at a free node");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && status_d == ST_FULL) |-> (&used_q))
    else $error("pool full reported with a free node");
`endif

endmodule

// File: sv/dlq_free_enc.sv
module dlq_free_enc (
  input  logic [dlq_pkg::DLQ_POOL_DEPTH-1:0] used_i,
  output logic                               found_o,
  output logic [dlq_pkg::HANDLE_W-1:0]       idx_o
);
  import dlq_pkg::*;

  // Lowest-numbered free node wins.
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = DLQ_POOL_DEPTH - 1; i >= 0; i--) begin
      if (!used_i[i]) begin
        found_o = 1'b1;
        idx_o   = HANDLE_W'(i);
      end
    end
  end

endmodule

// File: sv/dlq_node_store.sv
module dlq_node_store #(
  parameter int VALUE_WIDTH = dlq_pkg::DLQ_VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  dlq_pkg::node_wr_t             wr_i,
  input  logic [VALUE_WIDTH-1:0]        wr_value_i,
  input  logic [dlq_pkg::HANDLE_W-1:0]  rd_idx_i,
  output logic [VALUE_WIDTH-1:0]        rd_value_o,
  output logic [dlq_pkg::LINK_W-1:0]    rd_next_o,
  output logic [dlq_pkg::LINK_W-1:0]    rd_prev_o
);
  import dlq_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q  [DLQ_POOL_DEPTH];
  logic [LINK_W-1:0]      next_q [DLQ_POOL_DEPTH];
  logic [LINK_W-1:0]      prev_q [DLQ_POOL_DEPTH];

  // Entries hold no reset; a node is only read once it has been allocated.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DLQ_POOL_DEPTH; i++) begin
      if (wr_en_i) begin
        if (wr_i.alloc_en && wr_i.alloc_idx == HANDLE_W'(i)) begin
          val_q[i]  <= wr_value_i;
          next_q[i] <= wr_i.alloc_next;
          prev_q[i] <= wr_i.alloc_prev;
        end
        // neighbor patches land after the alloc write
        if (wr_i.nlink_en && wr_i.nlink_idx == HANDLE_W'(i)) begin
          next_q[i] <= wr_i.nlink_val;
        end
        if (wr_i.plink_en && wr_i.plink_idx == HANDLE_W'(i)) begin
          prev_q[i] <= wr_i.plink_val;
        end
      end
    end
  end

  assign rd_value_o = val_q[rd_idx_i];
  assign rd_next_o  = next_q[rd_idx_i];
  assign rd_prev_o  = prev_q[rd_idx_i];

endmodule

// File: bench/linked_deque_node_pool_tb.sv
`timescale 1ns / 1ps

module linked_deque_node_pool_tb;
  import dlq_pkg::*;

  localparam int IN_W  = ((DLQ_VALUE_WIDTH + HANDLE_W + 7) / 8) * 8;
  localparam int OUT_W = ((DLQ_VALUE_WIDTH + 6 * LINK_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1330;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLDOFF_CYCLES = 100;
  localparam int DRAIN_CYCLES = 10;

  // One request item as offered on s_axis.
  typedef struct {
    logic [2:0]                 req;
    logic [DLQ_VALUE_WIDTH-1:0] value;
    logic [HANDLE_W-1:0]        handle;
  } deque_req_t;

  // One result item as seen on m_axis.
  typedef struct {
    logic [1:0]                 status;
    logic [DLQ_VALUE_WIDTH-1:0] value;
    logic [LINK_W-1:0]          node;
    logic [LINK_W-1:0]          nxt;
    logic [LINK_W-1:0]          prv;
    logic [LINK_W-1:0]          head;
    logic [LINK_W-1:0]          tail;
    logic [LINK_W-1:0]          cnt;
  } deque_result_t;

  // Request mixes for the random part: each phase leans toward one of them.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_PROBE} mix_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic [2:0]       s_tuser  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  linked_deque_node_pool uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // item_value, node_handle
    .s_axis_tuser_i  (s_tuser),   // req_type
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // value_out, node_out, next_out, prev_out, head_out, tail_out, count_out
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)    // status
  );

  // ---------------------------------------------------------------------
  // Shadow deque: node pool, free map and end pointers.
  // ---------------------------------------------------------------------
  logic [DLQ_VALUE_WIDTH-1:0] pool_val [DLQ_POOL_DEPTH];
  logic [LINK_W-1:0]          pool_nxt [DLQ_POOL_DEPTH];
  logic [LINK_W-1:0]          pool_prv [DLQ_POOL_DEPTH];
  logic [DLQ_POOL_DEPTH-1:0]  pool_used = '0;
  logic [LINK_W-1:0]          q_head    = NO_NODE;
  logic [LINK_W-1:0]          q_tail    = NO_NODE;
  logic [LINK_W-1:0]          q_count   = '0;

  deque_req_t    request_queue [$];
  deque_result_t expected_results [$];
  int            error_count = 0;

  // Lowest-numbered free node, NO_NODE when the pool is full.
  function automatic logic [LINK_W-1:0] lowest_free();
    for (int i = 0; i < DLQ_POOL_DEPTH; i++)
      if (!pool_used[i]) return LINK_W'(i);
    return NO_NODE;
  endfunction

  // Splice a used node out of the chain and return it to the pool.
  function automatic void unlink_node(input logic [LINK_W-1:0] n);
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] x;
    p = pool_prv[n[HANDLE_W-1:0]];
    x = pool_nxt[n[HANDLE_W-1:0]];
    if (n == q_head) q_head = x;
    if (n == q_tail) q_tail = p;
    if (p != NO_NODE) pool_nxt[p[HANDLE_W-1:0]] = x;
    if (x != NO_NODE) pool_prv[x[HANDLE_W-1:0]] = p;
    pool_used[n[HANDLE_W-1:0]] = 1'b0;
    if (q_count > 0) q_count--;
  endfunction

  // Apply one request to the shadow deque and return the result it gives.
  function automatic deque_result_t apply_request(input deque_req_t rq);
    deque_result_t r;
    logic [LINK_W-1:0] f;
    logic [LINK_W-1:0] t;
    r.status = ST_OK;
    r.value  = '0;
    r.node   = NO_NODE;
    r.nxt    = NO_NODE;
    r.prv    = NO_NODE;
    case (rq.req)
      REQ_APPEND, REQ_PREPEND: begin
        f = lowest_free();
        if (f == NO_NODE) begin
          r.status = ST_FULL;
        end else begin
          pool_used[f[HANDLE_W-1:0]] = 1'b1;
          pool_val[f[HANDLE_W-1:0]]  = rq.value;
          if (q_count == 0) begin
            pool_prv[f[HANDLE_W-1:0]] = NO_NODE;
            pool_nxt[f[HANDLE_W-1:0]] = NO_NODE;
            q_head = f;
            q_tail = f;
          end else if (rq.req == REQ_APPEND) begin
            pool_prv[f[HANDLE_W-1:0]]      = q_tail;
            pool_nxt[f[HANDLE_W-1:0]]      = NO_NODE;
            pool_nxt[q_tail[HANDLE_W-1:0]] = f;
            q_tail = f;
          end else begin
            pool_prv[f[HANDLE_W-1:0]]      = NO_NODE;
            pool_nxt[f[HANDLE_W-1:0]]      = q_head;
            pool_prv[q_head[HANDLE_W-1:0]] = f;
            q_head = f;
          end
          q_count++;
          r.node = f;
        end
      end
      REQ_POP_L, REQ_POP_R: begin
        t = (rq.req == REQ_POP_L) ? q_head : q_tail;
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = pool_val[t[HANDLE_W-1:0]];
          r.node  = t;
          unlink_node(t);
        end
      end
      REQ_REMOVE: begin
        if (!pool_used[rq.handle]) begin
          r.status = ST_BAD;
        end else begin
          r.node = LINK_W'(rq.handle);
          unlink_node(LINK_W'(rq.handle));
        end
      end
      REQ_READ: begin
        if (!pool_used[rq.handle]) begin
          r.status = ST_BAD;
        end else begin
          r.value = pool_val[rq.handle];
          r.node  = LINK_W'(rq.handle);
          r.nxt   = pool_nxt[rq.handle];
          r.prv   = pool_prv[rq.handle];
        end
      end
      default: ;  // undefined request: no change, state echoed
    endcase
    if (q_count == 0) begin
      q_head = NO_NODE;
      q_tail = NO_NODE;
    end
    r.head = q_head;
    r.tail = q_tail;
    r.cnt  = q_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_req(input logic [2:0] req, input logic [DLQ_VALUE_WIDTH-1:0] value,
                          input logic [HANDLE_W-1:0] handle);
    deque_req_t rq;
    rq.req    = req;
    rq.value  = value;
    rq.handle = handle;
    request_queue.push_back(rq);
  endtask

  function automatic logic [DLQ_VALUE_WIDTH-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return DLQ_VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic deque_req_t random_request(input mix_e mix);
    deque_req_t rq;
    int roll;
    int grow_lim;
    int pop_lim;
    roll      = $urandom_range(0, 99);
    rq.value  = random_value();
    rq.handle = HANDLE_W'($urandom_range(0, DLQ_POOL_DEPTH - 1));
    case (mix)
      MIX_GROW:   begin grow_lim = 65; pop_lim = 80; end
      MIX_SHRINK: begin grow_lim = 20; pop_lim = 75; end
      MIX_MIXED:  begin grow_lim = 40; pop_lim = 70; end
      default:    begin grow_lim = 35; pop_lim = 45; end
    endcase
    if (roll < 2)
      rq.req = 3'($urandom_range(6, 7));  // undefined codes, rare
    else if (roll < grow_lim)
      rq.req = $urandom_range(0, 1) ? REQ_APPEND : REQ_PREPEND;
    else if (roll < pop_lim)
      rq.req = $urandom_range(0, 1) ? REQ_POP_L : REQ_POP_R;
    else
      rq.req = $urandom_range(0, 1) ? REQ_REMOVE : REQ_READ;
    return rq;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : stimulus
    int made;
    int phase_len;
    mix_e mix;

    // Directed: empty-deque cases, both value extremes, fill to the pool
    // limit, overflow on both ends, unlink from the middle, undefined codes.
    push_req(REQ_POP_L, '0, '0);
    push_req(REQ_POP_R, '0, '0);
    push_req(REQ_READ, '0, 4'd0);
    push_req(REQ_REMOVE, '1, 4'd15);
    push_req(REQ_APPEND, '0, '0);
    push_req(REQ_PREPEND, '1, '1);
    push_req(REQ_READ, '0, 4'd0);
    push_req(REQ_READ, '0, 4'd1);
    for (int i = 0; i < DLQ_POOL_DEPTH - 2; i++)
      push_req((i % 2) ? REQ_PREPEND : REQ_APPEND, DLQ_VALUE_WIDTH'($urandom), '0);
    push_req(REQ_APPEND, 32'h1234_5678, '0);
    push_req(REQ_PREPEND, 32'h8765_4321, '0);
    push_req(REQ_REMOVE, '0, 4'd7);
    push_req(REQ_POP_L, '0, '0);
    push_req(REQ_POP_R, '0, '0);
    push_req(3'd6, '1, '1);
    push_req(3'd7, '0, '0);

    // Random phases, each leaning toward growth, drain, a mix or probing.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mix = mix_e'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len && made < RANDOM_ITEMS; i++) begin
        request_queue.push_back(random_request(mix));
        made++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last item out, then for the pipeline to settle.
    while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of random length with random gaps in between.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin : drive
    logic       next_valid;
    deque_req_t rq;
    next_valid = s_tvalid;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        rq = request_queue.pop_front();
        expected_results.push_back(apply_request(rq));
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = $urandom_range(0, 6);
          // now and then a long burst with no idling at all
          burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
        end
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() != 0) begin
          next_valid = 1'b1;
          s_tdata <= IN_W'({request_queue[0].handle, request_queue[0].value});
          s_tuser <= request_queue[0].req;
        end
      end
    end
    s_tvalid <= next_valid;
  end

  // ---------------------------------------------------------------------
  // Monitor: result check plus a receiver stall pattern of its own.
  // ---------------------------------------------------------------------
  int monitor_cycle = 0;
  int stall_pct     = 0;
  int results_seen  = 0;
  int holdoffs_done = 0;
  int holdoff_left  = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    deque_result_t want;
    logic          next_ready;
    if (rst_ni && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %0h/%0h",
                 $time, m_tuser, m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("value_out", 32'(want.value), 32'(m_tdata[31:0]));
        check_field("node_out", 32'(want.node), 32'(m_tdata[36:32]));
        check_field("next_out", 32'(want.nxt), 32'(m_tdata[41:37]));
        check_field("prev_out", 32'(want.prv), 32'(m_tdata[46:42]));
        check_field("head_out", 32'(want.head), 32'(m_tdata[51:47]));
        check_field("tail_out", 32'(want.tail), 32'(m_tdata[56:52]));
        check_field("count_out", 32'(want.cnt), 32'(m_tdata[61:57]));
      end
    end

    // stall level is redrawn at intervals from: none, light, half, heavy
    if (monitor_cycle % 64 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    monitor_cycle++;

    // Long hold-off twice in the run so the block backs up into s_axis.
    if (holdoff_left == 0 && holdoffs_done < 2 && results_seen >= 300 * (holdoffs_done + 1)) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoffs_done++;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      next_ready = 1'b0;
    end else begin
      next_ready = ($urandom_range(0, 99) >= stall_pct);
    end
    m_tready <= next_ready;
  end

endmodule
